// ===== rtl/psrm_pkg.sv =====
// Shared types, constants and codes of the per-source rate meter.
// Used by every module of the block; depends on nothing.
package psrm_pkg;

   localparam int FLOW_ENTRIES_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [31:0] INTERVAL_RESET = 32'd1000000;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam int PROD_W = 84;
   localparam int DIV_STEPS = 84;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] source_address;
      logic [15:0] byte_count;
      logic [23:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic [31:0] report_address;
      logic [47:0] rate_bytes_per_sec;
      logic [47:0] peak_rate;
      logic        timed_out;
      logic        last_report;
   } rsp_type;

   typedef enum logic {
      CMD_PACKET,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  address;
      logic [15:0]  byte_count;
      logic [23:0]  elapsed_us;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic [63:0] elapsed;
      logic [63:0] bytes;
      logic [63:0] report_time;
      logic [63:0] report_bytes;
      logic [47:0] peak;
   } entry_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PK_RD,
      BK_PK_CHK,
      BK_TK_RD,
      BK_TK_ADD,
      BK_TK_CMP,
      BK_TK_DIV,
      BK_TK_WB,
      BK_TK_END
   } back_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL_LO,
      DIV_MUL_HI,
      DIV_SUM,
      DIV_RUN,
      DIV_FIN
   } div_state_type;

endpackage

// ===== rtl/psrm_front.sv =====
// Front end: accepts commands, classifies them and holds them in a short queue.
// Depends on psrm_pkg.
module psrm_front
   import psrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   input  logic    clear_active,
   output logic    busy,
   input  logic    pop,
   output logic    cmd_valid,
   output cmd_type cmd
);

   localparam int QP_W = $clog2(QUEUE_DEPTH);

   cmd_type         queue_ff [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff;
   logic [QP_W:0]   count_ff;
   logic [QP_W-1:0] rd_ptr_ff;
   logic            push;
   cmd_type         cmd_in;

   // The queue refuses items while full and while the table is being cleared.
   assign busy = (count_ff == (QP_W+1)'(QUEUE_DEPTH)) || clear_active;
   assign push = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd = queue_ff[rd_ptr_ff];

   // Classify the item by its operation code.
   always_comb begin
      cmd_in.kind = (req_data.operation == OP_TICK) ? CMD_TICK : CMD_PACKET;
      cmd_in.address = req_data.source_address;
      cmd_in.byte_count = req_data.byte_count;
      cmd_in.elapsed_us = req_data.elapsed_us;
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/psrm_div.sv =====
// Rate unit: floor(bytes * 1000000 / time), saturated to 48 bits.
// Two partial products, one sum, then one restoring division step per cycle. Uses psrm_pkg.
module psrm_div
   import psrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] bytes_delta,
   input  logic [63:0] time_delta,
   output logic        done,
   output logic [47:0] quotient
);

   div_state_type      state_ff, state_in;
   logic [63:0]        b_ff;
   logic [63:0]        t_ff;
   logic [51:0]        plo_ff;
   logic [51:0]        phi_ff;
   logic [PROD_W-1:0]  num_ff;
   logic [63:0]        rem_ff;
   logic [47:0]        q_ff;
   logic               sat_ff;
   logic [6:0]         cnt_ff;
   logic [64:0]        rem_sh;
   logic               ge;
   logic [64:0]        rem_sub;

   // One step of the restoring division.
   assign rem_sh = {rem_ff, num_ff[PROD_W-1]};
   assign ge = (rem_sh >= {1'b0, t_ff});
   assign rem_sub = rem_sh - {1'b0, t_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE:   if (start) state_in = DIV_MUL_LO;
         DIV_MUL_LO: state_in = DIV_MUL_HI;
         DIV_MUL_HI: state_in = DIV_SUM;
         DIV_SUM:    state_in = DIV_RUN;
         DIV_RUN:    if (cnt_ff == 7'(DIV_STEPS - 1)) state_in = DIV_FIN;
         DIV_FIN:    state_in = DIV_IDLE;
         default:    state_in = DIV_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      done = (state_ff == DIV_FIN);
      quotient = sat_ff ? MAX48 : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         DIV_IDLE: begin
            b_ff <= bytes_delta;
            t_ff <= time_delta;
         end
         DIV_MUL_LO: plo_ff <= b_ff[31:0] * USEC_PER_SEC;
         DIV_MUL_HI: phi_ff <= b_ff[63:32] * USEC_PER_SEC;
         DIV_SUM: begin
            num_ff <= PROD_W'(plo_ff) + {phi_ff, 32'b0};
            rem_ff <= '0;
            q_ff <= '0;
            sat_ff <= 1'b0;
            cnt_ff <= '0;
         end
         DIV_RUN: begin
            num_ff <= {num_ff[PROD_W-2:0], 1'b0};
            rem_ff <= ge ? rem_sub[63:0] : rem_sh[63:0];
            q_ff <= {q_ff[46:0], ge};
            sat_ff <= sat_ff | q_ff[47];
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/psrm_back.sv =====
// Back end: flow table in a memory, table clear after reset, packet lookup walk and tick report walk.
// Depends on psrm_pkg and psrm_div.
module psrm_back
   import psrm_pkg::*;
#(
   parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        pop,
   input  logic [31:0] interval,
   output logic        clear_active,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

   back_state_type   state_ff, state_in;
   entry_type        mem [FLOW_ENTRIES];
   entry_type        rd_rec_ff;
   logic [IDX_W-1:0] idx_ff;
   cmd_type          cmd_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [63:0]      elapsed_ff;
   logic             bdel_zero_ff;
   logic             pend_valid_ff;
   rsp_type          pend_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             is_last;
   logic             hit;
   logic [63:0]      tdel;
   logic [63:0]      bdel;
   logic             due;
   logic             div_start;
   logic             div_done;
   logic [47:0]      rate;
   logic [47:0]      peak_new;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_rec;
   logic             rd_en;
   logic             emit_now;
   logic             emit_last;
   logic             adv;
   rsp_type          rsp_in;

   psrm_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .bytes_delta (bdel),
      .time_delta  (tdel),
      .done        (div_done),
      .quotient    (rate)
   );

   // Entry checks on the record just read.
   assign is_last = (idx_ff == LAST_IDX);
   assign hit = rd_rec_ff.valid && (rd_rec_ff.address == cmd_ff.address);
   assign tdel = elapsed_ff - rd_rec_ff.report_time;
   assign bdel = rd_rec_ff.bytes - rd_rec_ff.report_bytes;
   assign due = (tdel >= 64'(interval));
   assign peak_new = (rate > rd_rec_ff.peak) ? rate : rd_rec_ff.peak;
   assign clear_active = (state_ff == BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (is_last) state_in = BK_IDLE;
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.kind == CMD_TICK) ? BK_TK_RD : BK_PK_RD;
            end
         end
         BK_PK_RD:  state_in = BK_PK_CHK;
         BK_PK_CHK: state_in = (hit || is_last) ? BK_IDLE : BK_PK_RD;
         BK_TK_RD:  state_in = BK_TK_ADD;
         BK_TK_ADD: begin
            if (rd_rec_ff.valid) begin
               state_in = BK_TK_CMP;
            end else begin
               state_in = is_last ? BK_TK_END : BK_TK_RD;
            end
         end
         BK_TK_CMP: begin
            if (due) begin
               state_in = BK_TK_DIV;
            end else begin
               state_in = is_last ? BK_TK_END : BK_TK_RD;
            end
         end
         BK_TK_DIV: if (div_done) state_in = BK_TK_WB;
         BK_TK_WB:  state_in = is_last ? BK_TK_END : BK_TK_RD;
         BK_TK_END: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // Outputs: memory port, queue pop, divider start and report release.
   always_comb begin
      wr_en = 1'b0;
      wr_idx = idx_ff;
      wr_rec = rd_rec_ff;
      rd_en = 1'b0;
      pop = 1'b0;
      div_start = 1'b0;
      emit_now = 1'b0;
      emit_last = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en = 1'b1;
            wr_rec = '0;
         end
         BK_IDLE: pop = cmd_valid;
         BK_PK_RD, BK_TK_RD: rd_en = 1'b1;
         BK_PK_CHK: begin
            if (hit) begin
               wr_en = 1'b1;
               wr_rec.bytes = rd_rec_ff.bytes + 64'(cmd_ff.byte_count);
            end else if (is_last && (free_found_ff || !rd_rec_ff.valid)) begin
               wr_en = 1'b1;
               wr_idx = free_found_ff ? free_idx_ff : idx_ff;
               wr_rec = '0;
               wr_rec.valid = 1'b1;
               wr_rec.address = cmd_ff.address;
               wr_rec.bytes = 64'(cmd_ff.byte_count);
            end
         end
         BK_TK_CMP: begin
            if (due) begin
               div_start = 1'b1;
            end else begin
               wr_en = 1'b1;
               wr_rec.elapsed = elapsed_ff;
            end
         end
         BK_TK_WB: begin
            wr_en = 1'b1;
            wr_rec.valid = !bdel_zero_ff;
            wr_rec.elapsed = elapsed_ff;
            wr_rec.report_time = elapsed_ff;
            wr_rec.report_bytes = rd_rec_ff.bytes;
            wr_rec.peak = peak_new;
            emit_now = pend_valid_ff;
         end
         BK_TK_END: begin
            emit_now = pend_valid_ff;
            emit_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The released report takes its final-report mark from the walk position.
   always_comb begin
      rsp_in = pend_ff;
      rsp_in.last_report = emit_last;
   end

   // Index moves on whenever the walk goes to the next entry.
   assign adv = (state_in == BK_PK_RD || state_in == BK_TK_RD) && (state_ff != BK_IDLE);

   // Table memory with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[idx_ff];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         idx_ff <= '0;
         free_found_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_IDLE) begin
            idx_ff <= '0;
         end else if (state_ff == BK_CLEAR || adv) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff == BK_IDLE) begin
            free_found_ff <= 1'b0;
         end else if (state_ff == BK_PK_CHK && !rd_rec_ff.valid) begin
            free_found_ff <= 1'b1;
         end
         if (state_ff == BK_TK_WB) begin
            pend_valid_ff <= 1'b1;
         end else if (state_ff == BK_TK_END) begin
            pend_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= emit_now;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= cmd;
      end
      if (state_ff == BK_PK_CHK && !rd_rec_ff.valid && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
      if (state_ff == BK_TK_ADD) begin
         elapsed_ff <= rd_rec_ff.elapsed + 64'(cmd_ff.elapsed_us);
      end
      if (state_ff == BK_TK_CMP) begin
         bdel_zero_ff <= (bdel == '0);
      end
      // A report is held back one step so that the final one can be marked.
      if (state_ff == BK_TK_WB) begin
         pend_ff.report_address <= rd_rec_ff.address;
         pend_ff.rate_bytes_per_sec <= rate;
         pend_ff.peak_rate <= peak_new;
         pend_ff.timed_out <= bdel_zero_ff;
         pend_ff.last_report <= 1'b0;
      end
      if (emit_now) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/per_source_rate_meter_unit.sv =====
// Top level of the per-source rate meter: register port, front queue and back end.
// Depends on psrm_pkg, psrm_front and psrm_back.

// A packet command walks the flow table entry by entry, reading and then checking
// each, until its source is found or the last entry is checked; a tick walks every
// entry, and for each live one adds the elapsed time, compares the time since its
// last report with the interval and, when due, runs the shared rate divider.
// Commands wait in a four-deep queue; busy is high while it is full and while the
// table is cleared after reset. Reports come one cycle at a time on rsp_valid and
// cannot be held off; the last two reports of a tick can arrive in adjacent cycles,
// and the final one carries last_report. A report interval of zero acts as one microsecond.
module per_source_rate_meter_unit
   import psrm_pkg::*;
#(
   parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] interval_ff;
   logic [31:0] interval_eff;
   logic        clear_active;
   logic        pop;
   logic        cmd_valid;
   cmd_type     cmd;

   // Report interval register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_data;
      end
   end
   assign interval_eff = (interval_ff == '0) ? 32'd1 : interval_ff;

   psrm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .clear_active (clear_active),
      .busy         (busy),
      .pop          (pop),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd)
   );

   psrm_back #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .pop          (pop),
      .interval     (interval_eff),
      .clear_active (clear_active),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // A timed-out source had no bytes, so its rate is zero.
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |-> rsp_data.rate_bytes_per_sec == '0)
      else $error("timed-out report with nonzero rate");

   // The peak includes the rate being reported.
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.peak_rate >= rsp_data.rate_bytes_per_sec)
      else $error("peak rate below reported rate");

   // No command enters while the table is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> busy)
      else $error("input open during table clear");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for per_source_rate_meter_unit: directed and random packets and ticks.
// Depends on psrm_pkg and the RTL of the rate meter; nothing else.

// Keeps its own copy of the flow table and predicts every rate report.
class flow_rate_tracker;
   localparam int ENTRIES = 16;
   bit          live[ENTRIES];
   logic [31:0] addr[ENTRIES];
   logic [63:0] elapsed[ENTRIES];
   logic [63:0] bytes[ENTRIES];
   logic [63:0] rep_time[ENTRIES];
   logic [63:0] rep_bytes[ENTRIES];
   logic [47:0] peak[ENTRIES];
   logic [31:0] interval_us;
   psrm_pkg::rsp_type expected_reports[$];
   int mismatches;
   int reports_seen;
   int timeouts_seen;
   int saturated_seen;

   function new();
      interval_us = psrm_pkg::INTERVAL_RESET;
      mismatches = 0;
      reports_seen = 0;
      timeouts_seen = 0;
      saturated_seen = 0;
      foreach (live[i]) live[i] = 0;
   endfunction

   function int pending();
      return expected_reports.size();
   endfunction

   // floor(b * 1e6 / t), clamped to 48 bits.
   function logic [47:0] bytes_per_sec(logic [63:0] b, logic [63:0] t);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = {64'd0, b} * 128'd1000000;
      quo = prod / {64'd0, t};
      return (quo > {80'd0, psrm_pkg::MAX48}) ? psrm_pkg::MAX48 : quo[47:0];
   endfunction

   // Update the table for one accepted transfer and queue the reports it causes.
   function void note_input(psrm_pkg::req_type r);
      int free_slot;
      logic [63:0] span;
      logic [63:0] tdel;
      logic [63:0] bdel;
      logic [47:0] rate;
      psrm_pkg::rsp_type rsp;
      psrm_pkg::rsp_type tick_out[$];
      free_slot = -1;
      if (r.operation == psrm_pkg::OP_PACKET) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (live[i] && addr[i] == r.source_address) begin
               bytes[i] += r.byte_count;
               return;
            end
            if (!live[i] && free_slot < 0) free_slot = i;
         end
         // A new source takes the lowest free entry; with the table full it is dropped.
         if (free_slot >= 0) begin
            live[free_slot] = 1;
            addr[free_slot] = r.source_address;
            elapsed[free_slot] = 0;
            bytes[free_slot] = r.byte_count;
            rep_time[free_slot] = 0;
            rep_bytes[free_slot] = 0;
            peak[free_slot] = 0;
         end
         return;
      end
      span = (interval_us == 0) ? 64'd1 : {32'd0, interval_us};
      for (int i = 0; i < ENTRIES; i++) begin
         if (!live[i]) continue;
         elapsed[i] += r.elapsed_us;
         tdel = elapsed[i] - rep_time[i];
         if (tdel < span) continue;
         bdel = bytes[i] - rep_bytes[i];
         rate = bytes_per_sec(bdel, tdel);
         if (rate > peak[i]) peak[i] = rate;
         rep_time[i] = elapsed[i];
         rep_bytes[i] = bytes[i];
         rsp.report_address = addr[i];
         rsp.rate_bytes_per_sec = rate;
         rsp.peak_rate = peak[i];
         rsp.timed_out = (bdel == 0);
         rsp.last_report = 0;
         tick_out.push_back(rsp);
         if (bdel == 0) live[i] = 0;
      end
      if (tick_out.size() > 0) tick_out[tick_out.size() - 1].last_report = 1;
      foreach (tick_out[k]) expected_reports.push_back(tick_out[k]);
   endfunction

   function void report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endfunction

   // Compare one report transfer with the oldest prediction.
   function void check(psrm_pkg::rsp_type got);
      psrm_pkg::rsp_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch($sformatf("unexpected report for %h", got.report_address));
         return;
      end
      want = expected_reports.pop_front();
      reports_seen++;
      if (got.timed_out) timeouts_seen++;
      if (want.rate_bytes_per_sec == psrm_pkg::MAX48) saturated_seen++;
      if (got.report_address !== want.report_address)
         report_mismatch($sformatf("report_address %h, expected %h",
                                   got.report_address, want.report_address));
      if (got.rate_bytes_per_sec !== want.rate_bytes_per_sec)
         report_mismatch($sformatf("rate %0d, expected %0d",
                                   got.rate_bytes_per_sec, want.rate_bytes_per_sec));
      if (got.peak_rate !== want.peak_rate)
         report_mismatch($sformatf("peak %0d, expected %0d", got.peak_rate, want.peak_rate));
      if (got.timed_out !== want.timed_out)
         report_mismatch($sformatf("timed_out %b, expected %b", got.timed_out, want.timed_out));
      if (got.last_report !== want.last_report)
         report_mismatch($sformatf("last_report %b, expected %b",
                                   got.last_report, want.last_report));
   endfunction
endclass

module testbench;
   import psrm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 3000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   flow_rate_tracker tracker;
   int items_sent;
   int cycle_count = 0;
   logic [31:0] addr_pool[24];

   per_source_rate_meter_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Every report transfer is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check(rsp_data);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Hold start high until the transfer is taken; start stays high for a following item.
   task automatic send(req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      tracker.note_input(r);
      items_sent++;
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_packet(logic [31:0] a, logic [15:0] n);
      req_type r;
      r.operation = OP_PACKET;
      r.source_address = a;
      r.byte_count = n;
      r.elapsed_us = 24'($urandom);
      send(r);
   endtask

   task automatic send_tick(logic [23:0] dt);
      req_type r;
      r.operation = OP_TICK;
      r.source_address = $urandom;
      r.byte_count = 16'($urandom);
      r.elapsed_us = dt;
      send(r);
   endtask

   // Wait until every predicted report has come, then let queued commands finish.
   task automatic wait_idle();
      start <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.interval_us = v;
   endtask

   // One random phase: mostly packets from a small source pool, ticks near the interval.
   task automatic random_phase(int count, logic [31:0] iv, bit bursty);
      int burst;
      logic [23:0] dt;
      logic [63:0] span;
      span = (iv == 0) ? 64'd1 : {32'd0, iv};
      burst = $urandom_range(1, 8);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 22) begin
            case ($urandom_range(0, 5))
               0: dt = 0;
               1: dt = 24'($urandom);
               default: dt = (span > 64'd16777215) ? 24'($urandom) :
                             24'($urandom_range(0, 32'(span) * 2));
            endcase
            send_tick(dt);
         end else if ($urandom_range(0, 9) == 0) begin
            send_packet($urandom, 16'($urandom));
         end else begin
            send_packet(addr_pool[$urandom_range(0, 23)],
                        ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom));
         end
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            if (bursty) pause($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      logic [31:0] iv;
      tracker = new();
      items_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset interval, no reports; then interval 1 with extremes.
      send_packet(32'h0000_0000, 16'hFFFF);
      send_tick(24'd5);
      wait_idle();
      write_interval(32'd1);
      send_packet(32'hFFFF_FFFF, 16'd0);
      send_packet(32'hFFFF_FFFF, 16'd1);
      send_tick(24'hFF_FFFF);
      // One byte over three microseconds gives a nonzero rate; the idle source times out.
      send_packet(32'h0000_0000, 16'd1);
      send_tick(24'd0);
      send_tick(24'd3);
      // No bytes since the last report: the remaining entry times out and is freed.
      send_tick(24'd1);
      wait_idle();
      // Fill the table past its size so the last new sources are dropped.
      for (int i = 0; i < 18; i++) send_packet(addr_pool[i], 16'(i * 100));
      send_tick(24'd2);
      send_tick(24'd1);
      wait_idle();

      // Zero interval acts as one; a large byte delta over 1 us gives a very high rate.
      write_interval(32'd0);
      for (int i = 0; i < 30; i++) send_packet(32'hA5A5_5A5A, 16'hFFFF);
      send_tick(24'd1);
      send_tick(24'd1);
      wait_idle();

      // Random phases over several intervals, the extremes among them.
      random_phase(70, 32'd0, 1'b1);
      wait_idle();
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: iv = 32'd1;
            1: iv = 32'hFFFF_FFFF;
            2: iv = INTERVAL_RESET;
            3: iv = $urandom_range(2, 5000);
            default: iv = $urandom_range(5000, 2000000);
         endcase
         write_interval(iv);
         random_phase(p == 1 ? 40 : 60, iv, p != 3);
         wait_idle();
      end

      while (tracker.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending() > 0)
         tracker.report_mismatch($sformatf("%0d reports never came", tracker.pending()));
      $display("Covered %0d commands, %0d reports (%0d timeouts, %0d saturated).",
               items_sent, tracker.reports_seen, tracker.timeouts_seen,
               tracker.saturated_seen);
      $display("Intervals ran from zero to all ones, with table overflow and idle gaps.");
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
